>>> hw/rtl/tabbed_text_console_engine_macros.svh
// Assertion macros for the tabbed text console engine checker
`ifndef TABBED_TEXT_CONSOLE_ENGINE_MACROS_SVH
`define TABBED_TEXT_CONSOLE_ENGINE_MACROS_SVH

// same-cycle implication
`define CTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("console engine check failed");

// next-cycle implication
`define CTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("console engine check failed");

`endif

>>> hw/rtl/cte_pkg.sv
// Shared constants, types and helpers of the tabbed text console engine
`timescale 1ns / 1ps
package cte_pkg;
  localparam int TAB_COUNT = 4;
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;

  localparam int TAB_W  = (TAB_COUNT > 1) ? $clog2(TAB_COUNT) : 1;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ADDR_W = TAB_W + ROW_W + COL_W;

  localparam logic [7:0] HDR_TC_BASE = 8'h02;
  localparam logic [7:0] HDR_HC_BASE = 8'h20;
  localparam logic [7:0] HDR_HC_STEP = 8'h10;
  localparam logic [7:0] HDR_DASH    = 8'h2D;
  localparam logic [7:0] HDR_SLASH   = 8'h2F;
  localparam logic [7:0] HDR_SPACE   = 8'h20;
  localparam logic [7:0] HDR_ZERO    = 8'h30;
  localparam logic [7:0] NEWLINE     = 8'h0A;

  localparam logic [7:0] CFG_BLANK_CHAR    = 8'd0;
  localparam logic [7:0] CFG_DEFAULT_COLOR = 8'd1;

  typedef enum logic [2:0] {
    CMD_PUT    = 3'd0,
    CMD_BACK   = 3'd1,
    CMD_SWITCH = 3'd2,
    CMD_PROMPT = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [TAB_W-1:0] t,
                                                  input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return {t, r, c};
  endfunction
endpackage

>>> hw/rtl/cte_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read
`timescale 1ns / 1ps
module cte_ram #(
  parameter int AW = 8,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> hw/rtl/cte_header.sv
// Computed header row cell: tab digits with the active one highlighted
`timescale 1ns / 1ps
module cte_header import cte_pkg::*; (
  input  logic [TAB_W-1:0] tab_sel,
  input  logic [6:0]       col,
  output logic [15:0]      value
);
  localparam int AREA_END = 6 + 2 * TAB_COUNT + 1;

  logic [7:0] tc, hc, ch, co;
  logic [6:0] k;

  always_comb begin
    tc = HDR_TC_BASE + 8'(tab_sel) + 8'd1;
    hc = HDR_HC_BASE + 8'(HDR_HC_STEP * (8'(tab_sel) + 8'd1));
    k  = (col - 7'd7) >> 1;
    ch = HDR_DASH;
    co = tc;
    if (col == 7'd5) begin
      ch = HDR_SLASH;
    end else if (int'(col) >= 6 && int'(col) < AREA_END) begin
      if (!col[0]) begin
        ch = HDR_SPACE;
      end else begin
        ch = HDR_ZERO + 8'(k);
        if (int'(k) == int'(tab_sel)) co = hc;
      end
    end else if (int'(col) == AREA_END) begin
      ch = HDR_SLASH;
    end
    value = {co, ch};
  end
endmodule

>>> hw/rtl/tabbed_text_console_engine.sv
// Top level of the tabbed text console engine
// Usage:
//  Command channel: drive start with command and its operands; the beat is
//  taken at an edge where start is high and busy is low. busy stays high
//  until the result is shown.
//  Result: done is high for exactly one cycle with all result ports valid;
//  the receiver cannot stall and must take it in that cycle.
//  Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//  is the blank character, index 1 the default color. cfg_ready is always
//  high, also during the clearing pass.
//  Sequencing: done rises from the EXEC state for most commands, and from
//  the READ state, entered from EXEC, for a cell read (one cell store read).
//  No beat is taken while busy; the next beat can be taken at the edge that
//  ends the done cycle. A backspace at column 0 scans the row above one cell
//  per cycle. A put that scrolls copies rows through the cell store, one
//  cell per cycle, then drains the last pending copy and clears the bottom row.
//  Reset: synchronous; afterwards the cell store is cleared one entry per
//  cycle, all 2**(TAB_W+ROW_W+COL_W) entries (16384 here), with busy high.
`timescale 1ns / 1ps
module tabbed_text_console_engine import cte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [7:0]  char_code,
  input  logic [7:0]  color,
  input  logic [1:0]  tab,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic [1:0]  active_tab,
  output logic        cell_write,
  output logic [4:0]  cell_row,
  output logic [6:0]  cell_col,
  output logic [15:0] cell_value,
  output logic        scrolled,
  output logic [15:0] read_value
);
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_BSCAN = 7'b0010000,
    S_SCRL  = 7'b0100000,
    S_ZERO  = 7'b1000000
  } state_t;

  state_t state;
  logic [2:0] cmd_q;
  logic [7:0] ch_q, clr_q;
  logic [1:0] tab_q;
  logic [4:0] rrow_q;
  logic [6:0] rcol_q;
  logic [7:0] blank_q, dcolor_q;
  logic [TAB_W-1:0] sel_tab;
  logic [ROW_W-1:0] cur_row [TAB_COUNT];
  logic [COL_W-1:0] cur_col [TAB_COUNT];
  logic [ROW_W-1:0] prm_row [TAB_COUNT];
  logic [COL_W-1:0] prm_col [TAB_COUNT];
  logic [ADDR_W-1:0] clr_cnt;
  logic [COL_W-1:0] scan_col, scol, zcol;
  logic [ROW_W-1:0] bs_row, srow;
  logic issuing, pend;
  logic [ADDR_W-1:0] pend_addr;

  logic ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [15:0] ram_wdata, ram_rdata, hdr_value;

  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic in_range, pc_write, pc_wrap, pc_scroll, bs_stop, bs_more, rd_ok, rd_mem;
  logic [COL_W:0] pc_col1;
  logic [ROW_W:0] pc_row1;
  logic [ROW_W-1:0] pc_row_next;
  logic [COL_W-1:0] pc_col_next, bs_fin_col;
  logic [15:0] blank_val;

  cte_ram #(.AW(ADDR_W), .DW(16)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  cte_header u_hdr (.tab_sel(sel_tab), .col(rcol_q), .value(hdr_value));

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    row       = cur_row[sel_tab];
    col       = cur_col[sel_tab];
    blank_val = {dcolor_q, blank_q};
    in_range  = (int'(row) < ROWS) && (int'(col) < COLUMNS);
    pc_write  = (ch_q != NEWLINE) && (row != '0);
    pc_col1   = (ch_q != NEWLINE) ? {1'b0, col} + 1'b1 : {1'b0, col};
    pc_wrap   = (int'(pc_col1) >= COLUMNS) || (ch_q == NEWLINE);
    pc_row1   = pc_wrap ? {1'b0, row} + 1'b1 : {1'b0, row};
    pc_scroll = int'(pc_row1) >= ROWS;
    pc_row_next = pc_scroll ? ROW_W'(ROWS - 1) : pc_row1[ROW_W-1:0];
    pc_col_next = pc_wrap ? '0 : pc_col1[COL_W-1:0];
    bs_stop   = (col == '0 && int'(row) <= 1) ||
                (col == prm_col[sel_tab] && row == prm_row[sel_tab]) || !in_range;
    bs_more   = (ram_rdata[7:0] == blank_q) && (scan_col != '0);
    bs_fin_col = (ram_rdata[7:0] == blank_q) ? '0 : scan_col;
    rd_ok     = int'(rcol_q) < COLUMNS;
    rd_mem    = rd_ok && (rrow_q != 5'd0) && (int'(rrow_q) < ROWS);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      S_EXEC: begin
        case (cmd_q)
          CMD_PUT: begin
            if (in_range && pc_write) begin
              ram_we    = 1'b1;
              ram_waddr = cell_addr(sel_tab, row, col);
              ram_wdata = {clr_q, ch_q};
            end
          end
          CMD_BACK: begin
            if (!bs_stop && col != '0) begin
              ram_we    = 1'b1;
              ram_waddr = cell_addr(sel_tab, row, col - 1'b1);
              ram_wdata = blank_val;
            end else if (!bs_stop) begin
              ram_re    = 1'b1;
              ram_raddr = cell_addr(sel_tab, row - 1'b1, COL_W'(COLUMNS - 1));
            end
          end
          CMD_READ: begin
            ram_re    = rd_mem;
            ram_raddr = cell_addr(sel_tab, ROW_W'(rrow_q), COL_W'(rcol_q));
          end
          default: ;
        endcase
      end
      S_BSCAN: begin
        if (bs_more) begin
          ram_re    = 1'b1;
          ram_raddr = cell_addr(sel_tab, bs_row, scan_col - 1'b1);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cell_addr(sel_tab, bs_row, bs_fin_col);
          ram_wdata = blank_val;
        end
      end
      S_SCRL: begin
        ram_we    = pend;
        ram_waddr = pend_addr;
        ram_wdata = ram_rdata;
        ram_re    = issuing;
        ram_raddr = cell_addr(sel_tab, srow + 1'b1, scol);
      end
      S_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(sel_tab, ROW_W'(ROWS - 1), zcol);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      done     <= 1'b0;
      sel_tab  <= '0;
      blank_q  <= 8'd32;
      dcolor_q <= 8'd7;
      issuing  <= 1'b0;
      pend     <= 1'b0;
      for (int i = 0; i < TAB_COUNT; i++) begin
        cur_row[i] <= ROW_W'(1);
        cur_col[i] <= '0;
        prm_row[i] <= '0;
        prm_col[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BLANK_CHAR) blank_q <= cfg_data;
        else if (cfg_index == CFG_DEFAULT_COLOR) dcolor_q <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cmd_q  <= command;
            ch_q   <= char_code;
            clr_q  <= color;
            tab_q  <= tab;
            rrow_q <= read_row;
            rcol_q <= read_col;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          cell_write <= 1'b0;
          cell_row   <= '0;
          cell_col   <= '0;
          cell_value <= '0;
          scrolled   <= 1'b0;
          read_value <= '0;
          cursor_row <= 5'(row);
          cursor_col <= 7'(col);
          active_tab <= 2'(sel_tab);
          state      <= S_IDLE;
          done       <= 1'b1;
          case (cmd_q)
            CMD_PUT: begin
              if (in_range) begin
                cell_write <= pc_write;
                if (pc_write) begin
                  cell_row   <= 5'(row);
                  cell_col   <= 7'(col);
                  cell_value <= {clr_q, ch_q};
                end
                cur_row[sel_tab] <= pc_row_next;
                cur_col[sel_tab] <= pc_col_next;
                cursor_row <= 5'(pc_row_next);
                cursor_col <= 7'(pc_col_next);
                if (pc_scroll) begin
                  scrolled <= 1'b1;
                  srow     <= ROW_W'(1);
                  scol     <= '0;
                  zcol     <= '0;
                  issuing  <= 1'b1;
                  pend     <= 1'b0;
                  state    <= S_SCRL;
                  done     <= 1'b0;
                end
              end
            end
            CMD_BACK: begin
              if (!bs_stop && col != '0) begin
                cur_col[sel_tab] <= col - 1'b1;
                cursor_col <= 7'(col - 1'b1);
                cell_write <= 1'b1;
                cell_row   <= 5'(row);
                cell_col   <= 7'(col - 1'b1);
                cell_value <= blank_val;
              end else if (!bs_stop) begin
                bs_row   <= row - 1'b1;
                scan_col <= COL_W'(COLUMNS - 1);
                state    <= S_BSCAN;
                done     <= 1'b0;
              end
            end
            CMD_SWITCH: begin
              if (int'(tab_q) < TAB_COUNT && TAB_W'(tab_q) != sel_tab) begin
                sel_tab    <= TAB_W'(tab_q);
                active_tab <= tab_q;
                cursor_row <= 5'(cur_row[TAB_W'(tab_q)]);
                cursor_col <= 7'(cur_col[TAB_W'(tab_q)]);
              end
            end
            CMD_PROMPT: begin
              prm_row[sel_tab] <= row;
              prm_col[sel_tab] <= col;
            end
            CMD_READ: begin
              if (rd_mem) begin
                state <= S_READ;
                done  <= 1'b0;
              end else if (rd_ok && rrow_q == 5'd0) begin
                read_value <= hdr_value;
              end
            end
            default: ;
          endcase
        end
        S_READ: begin
          read_value <= ram_rdata;
          state      <= S_IDLE;
          done       <= 1'b1;
        end
        S_BSCAN: begin
          if (bs_more) begin
            scan_col <= scan_col - 1'b1;
          end else begin
            cur_row[sel_tab] <= bs_row;
            cur_col[sel_tab] <= bs_fin_col;
            cursor_row <= 5'(bs_row);
            cursor_col <= 7'(bs_fin_col);
            cell_write <= 1'b1;
            cell_row   <= 5'(bs_row);
            cell_col   <= 7'(bs_fin_col);
            cell_value <= blank_val;
            state      <= S_IDLE;
            done       <= 1'b1;
          end
        end
        S_SCRL: begin
          if (issuing) begin
            pend      <= 1'b1;
            pend_addr <= cell_addr(sel_tab, srow, scol);
            if (int'(scol) == COLUMNS - 1) begin
              scol <= '0;
              srow <= srow + 1'b1;
              if (int'(srow) == ROWS - 2) issuing <= 1'b0;
            end else begin
              scol <= scol + 1'b1;
            end
          end else begin
            pend  <= 1'b0;
            state <= S_ZERO;
          end
        end
        S_ZERO: begin
          zcol <= zcol + 1'b1;
          if (int'(zcol) == COLUMNS - 1) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/cte_checker.sv
// Port-level checker for the tabbed text console engine, bound to the top level
`timescale 1ns / 1ps
`include "tabbed_text_console_engine_macros.svh"
module cte_checker import cte_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        cell_write,
  input logic [4:0]  cell_row,
  input logic [15:0] cell_value,
  input logic [4:0]  cursor_row
);
  `CTE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `CTE_ASSERT_NEXT(a_done_single, done, !done)
  `CTE_ASSERT_NOW(a_done_idle, done, !busy)
  `CTE_ASSERT_NOW(a_no_write_zero, done && !cell_write, cell_value == 16'd0 && cell_row == 5'd0)
  `CTE_ASSERT_NOW(a_cursor_text, done, cursor_row != 5'd0 && int'(cursor_row) < ROWS)
endmodule

bind tabbed_text_console_engine cte_checker u_cte_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .cell_write(cell_write), .cell_row(cell_row), .cell_value(cell_value),
  .cursor_row(cursor_row)
);

>>> tb/sv/testbench.sv
// Self-checking testbench for the tabbed text console engine
`timescale 1ns / 1ps
module testbench;
  import cte_pkg::*;

  localparam int LIMIT = 12_000_000;
  localparam int N_RANDOM = 1130;
  localparam int N_PHASES = 8;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [7:0] color;
    logic [1:0] tab;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } cmd_beat_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [1:0]  active_tab;
    logic        cell_write;
    logic [4:0]  cell_row;
    logic [6:0]  cell_col;
    logic [15:0] cell_value;
    logic        scrolled;
    logic [15:0] read_value;
  } status_t;

  typedef struct {
    cmd_beat_t   beat;
    logic        typed;
    logic [15:0] read_exp;
  } dir_row_t;

  logic clk = 0, rst = 1;
  logic start = 0, busy;
  logic [2:0] command = '0;
  logic [7:0] char_code = '0, color = '0;
  logic [1:0] tab = '0;
  logic [4:0] read_row = '0;
  logic [6:0] read_col = '0;
  logic cfg_valid = 0, cfg_ready;
  logic [7:0] cfg_index = '0, cfg_data = '0;
  logic done;
  status_t got;

  tabbed_text_console_engine dut (
    .clk, .rst, .start, .busy, .command, .char_code, .color, .tab,
    .read_row, .read_col, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .done, .cursor_row(got.cursor_row), .cursor_col(got.cursor_col),
    .active_tab(got.active_tab), .cell_write(got.cell_write),
    .cell_row(got.cell_row), .cell_col(got.cell_col),
    .cell_value(got.cell_value), .scrolled(got.scrolled),
    .read_value(got.read_value)
  );

  always #5 clk = ~clk;

  // console image
  logic [15:0] screen [TAB_COUNT][ROWS][COLUMNS];
  int cur_row [TAB_COUNT];
  int cur_col [TAB_COUNT];
  int mark_row [TAB_COUNT];
  int mark_col [TAB_COUNT];
  int sel_tab;
  logic [7:0] blank_ch, blank_color;

  status_t pending_status [$];
  int errors = 0;
  int cycles = 0;
  int sender_idle_pct = 0;

  function automatic logic [15:0] header_cell(int t, int c);
    logic [7:0] tc, hc, ch, co;
    int area_end;
    tc = 8'(HDR_TC_BASE + t + 1);
    hc = 8'(HDR_HC_BASE + HDR_HC_STEP * (t + 1));
    ch = HDR_DASH;
    co = tc;
    area_end = 6 + 2 * TAB_COUNT + 1;
    if (c == 5) begin
      ch = HDR_SLASH;
    end else if (c >= 6 && c < area_end) begin
      if (c % 2 == 0) begin
        ch = HDR_SPACE;
      end else begin
        ch = 8'(HDR_ZERO + (c - 7) / 2);
        if ((c - 7) / 2 == t) co = hc;
      end
    end else if (c == area_end) begin
      ch = HDR_SLASH;
    end
    return {co, ch};
  endfunction

  function automatic void console_reset();
    foreach (screen[t, r, c]) screen[t][r][c] = '0;
    for (int t = 0; t < TAB_COUNT; t++) begin
      cur_row[t] = 1; cur_col[t] = 0; mark_row[t] = 0; mark_col[t] = 0;
    end
    sel_tab = 0;
    blank_ch = 8'd32;
    blank_color = 8'd7;
  endfunction

  function automatic status_t console_step(cmd_beat_t b);
    status_t s;
    int t, row, col, last;
    s = '0;
    t = sel_tab;
    row = cur_row[t];
    col = cur_col[t];
    case (b.command)
      CMD_PUT: begin
        if (b.char_code != NEWLINE) begin
          s.cell_value = {b.color, b.char_code};
          screen[t][row][col] = s.cell_value;
          s.cell_write = 1;
          s.cell_row = 5'(row);
          s.cell_col = 7'(col);
          col++;
        end
        if (col >= COLUMNS || b.char_code == NEWLINE) begin
          row++;
          col = 0;
        end
        if (row >= ROWS) begin
          row = ROWS - 1;
          for (int r = 1; r + 1 < ROWS; r++)
            for (int c = 0; c < COLUMNS; c++) screen[t][r][c] = screen[t][r + 1][c];
          for (int c = 0; c < COLUMNS; c++) screen[t][ROWS - 1][c] = '0;
          s.scrolled = 1;
        end
      end
      CMD_BACK: begin
        if (!((col == 0 && row <= 1) || (col == mark_col[t] && row == mark_row[t]))) begin
          if (col == 0) begin
            row--;
            last = COLUMNS - 1;
            while (last > 0 && screen[t][row][last][7:0] == blank_ch) last--;
            col = (screen[t][row][last][7:0] == blank_ch) ? 0 : last;
          end else begin
            col--;
          end
          s.cell_value = {blank_color, blank_ch};
          screen[t][row][col] = s.cell_value;
          s.cell_write = 1;
          s.cell_row = 5'(row);
          s.cell_col = 7'(col);
        end
      end
      CMD_SWITCH: begin
        if (b.tab < TAB_COUNT && b.tab != t) begin
          t = b.tab;
          row = cur_row[t];
          col = cur_col[t];
        end
      end
      CMD_PROMPT: begin
        mark_col[t] = col;
        mark_row[t] = row;
      end
      CMD_READ: begin
        if (b.read_col < COLUMNS) begin
          if (b.read_row == 0) s.read_value = header_cell(t, b.read_col);
          else if (b.read_row < ROWS) s.read_value = screen[t][b.read_row][b.read_col];
        end
      end
      default: ;
    endcase
    sel_tab = t;
    cur_row[t] = row;
    cur_col[t] = col;
    s.cursor_row = 5'(row);
    s.cursor_col = 7'(col);
    s.active_tab = 2'(t);
    return s;
  endfunction

  // one beat on the command channel; returns when accepted
  task automatic send_beat(cmd_beat_t b, logic typed = 0, logic [15:0] read_exp = '0);
    status_t s;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    {command, char_code, color, tab, read_row, read_col} <= b;
    do @(posedge clk); while (busy);
    s = console_step(b);
    if (typed) s.read_value = read_exp;
    pending_status.push_back(s);
  endtask

  task automatic wait_drained();
    start <= 0;
    while (pending_status.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last beat
  task automatic write_reg(logic [7:0] idx, logic [7:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_BLANK_CHAR) blank_ch = data;
    else blank_color = data;
  endtask

  function automatic cmd_beat_t random_beat(int newline_pct);
    cmd_beat_t b;
    int pick;
    b.char_code = 8'($urandom);
    b.color = 8'($urandom);
    b.tab = 2'($urandom);
    b.read_row = ($urandom_range(99) < 85) ? 5'($urandom_range(ROWS - 1)) : 5'($urandom);
    b.read_col = ($urandom_range(99) < 85) ? 7'($urandom_range(COLUMNS - 1)) : 7'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) begin
      b.command = CMD_PUT;
      if ($urandom_range(99) < newline_pct) b.char_code = NEWLINE;
    end else if (pick < 73) b.command = CMD_BACK;
    else if (pick < 80) b.command = CMD_SWITCH;
    else if (pick < 85) b.command = CMD_PROMPT;
    else if (pick < 99) b.command = CMD_READ;
    else b.command = 3'($urandom_range(5, 7));
    return b;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, got %p", $time, got);
      end else begin
        if (got !== pending_status[0]) begin
          errors++;
          $display("%0t: mismatch expected %p got %p", $time, pending_status[0], got);
        end
        void'(pending_status.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[tabbed_text_console_engine] ERROR");
      $finish;
    end
  end

  dir_row_t directed [] = '{
    '{'{CMD_READ, 8'd0, 8'd0, 2'd0, 5'd0, 7'd0}, 1, 16'h032D},
    '{'{CMD_READ, 8'd0, 8'd0, 2'd0, 5'd0, 7'd7}, 1, 16'h3030},
    '{'{CMD_READ, 8'd0, 8'd0, 2'd0, 5'd0, 7'd15}, 1, 16'h032F},
    '{'{CMD_READ, 8'd0, 8'd0, 2'd0, 5'd0, 7'd5}, 1, 16'h032F},
    '{'{CMD_READ, 8'd0, 8'd0, 2'd0, 5'd30, 7'd3}, 1, 16'h0000},
    '{'{CMD_READ, 8'd0, 8'd0, 2'd0, 5'd1, 7'd100}, 1, 16'h0000},
    '{'{CMD_READ, 8'd0, 8'd0, 2'd0, 5'd31, 7'd127}, 1, 16'h0000},
    '{'{CMD_BACK, 8'd0, 8'd0, 2'd0, 5'd0, 7'd0}, 0, 16'h0},
    '{'{CMD_PUT, 8'h41, 8'hFF, 2'd0, 5'd0, 7'd0}, 0, 16'h0},
    '{'{CMD_PUT, 8'hFF, 8'h00, 2'd0, 5'd0, 7'd0}, 0, 16'h0},
    '{'{CMD_PUT, 8'h00, 8'h55, 2'd0, 5'd0, 7'd0}, 0, 16'h0},
    '{'{CMD_PROMPT, 8'd0, 8'd0, 2'd0, 5'd0, 7'd0}, 0, 16'h0},
    '{'{CMD_BACK, 8'd0, 8'd0, 2'd0, 5'd0, 7'd0}, 0, 16'h0},
    '{'{CMD_PUT, NEWLINE, 8'hAA, 2'd0, 5'd0, 7'd0}, 0, 16'h0},
    '{'{CMD_BACK, 8'd0, 8'd0, 2'd0, 5'd0, 7'd0}, 0, 16'h0},
    '{'{CMD_SWITCH, 8'd0, 8'd0, 2'd3, 5'd0, 7'd0}, 0, 16'h0},
    '{'{CMD_SWITCH, 8'd0, 8'd0, 2'd3, 5'd0, 7'd0}, 0, 16'h0},
    '{'{CMD_READ, 8'd0, 8'd0, 2'd0, 5'd0, 7'd13}, 1, 16'h6033},
    '{'{CMD_SWITCH, 8'd0, 8'd0, 2'd0, 5'd0, 7'd0}, 0, 16'h0},
    '{'{3'd5, 8'd0, 8'd0, 2'd1, 5'd0, 7'd0}, 0, 16'h0},
    '{'{3'd6, 8'd0, 8'd0, 2'd2, 5'd0, 7'd0}, 0, 16'h0},
    '{'{3'd7, 8'hFF, 8'hFF, 2'd3, 5'd31, 7'd127}, 0, 16'h0},
    '{'{CMD_READ, 8'd0, 8'd0, 2'd0, 5'd1, 7'd0}, 1, 16'hFF41},
    '{'{CMD_READ, 8'd0, 8'd0, 2'd0, 5'd24, 7'd79}, 0, 16'h0}
  };

  logic [7:0] blank_set [N_PHASES] = '{8'd32, 8'd0, 8'd255, 8'd32, 8'd0, 8'd65, 8'd255, 8'd32};
  logic [7:0] color_set [N_PHASES] = '{8'd7, 8'd255, 8'd0, 8'd7, 8'd128, 8'd0, 8'd255, 8'd7};
  int idle_set [4] = '{0, 51, 0, 11};

  initial begin
    console_reset();
    repeat (4) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) send_beat(directed[i].beat, directed[i].typed, directed[i].read_exp);
    wait_drained();
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(CFG_BLANK_CHAR, blank_set[p]);
      write_reg(CFG_DEFAULT_COLOR, color_set[p]);
      cfg_valid <= 0;
      sender_idle_pct = idle_set[p % 4];
      for (int i = 0; i < N_RANDOM / N_PHASES; i++) begin
        // pause mid-phase until all results are back
        if (p == 2 && i == 60) wait_drained();
        send_beat(random_beat((p % 2 == 0) ? 25 : 2));
      end
      wait_drained();
    end
    repeat (20) @(posedge clk);
    if (errors == 0) $display("[tabbed_text_console_engine] OK");
    else $display("[tabbed_text_console_engine] ERROR");
    $finish;
  end
endmodule
